// ===== hw/rtl/tmcw_pkg.sv =====
// shared types and constants for the text mode console writer
`default_nettype none

package tmcw_pkg;

    localparam int KIND_W    = 3;
    localparam int CHAR_W    = 8;
    localparam int COL_F_W   = 7;
    localparam int ROW_F_W   = 5;
    localparam int IDX_F_W   = 11;
    localparam int CELL_W    = 16;
    localparam int CCMP_W    = 9;
    localparam int RCMP_W    = 8;

    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BACK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h05;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_BLANK
    } tmcw_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tmcw_screen_ram.sv =====
// screen cell memory, one write port and one registered read port
`default_nettype none

module tmcw_screen_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 16
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tmcw_ctrl.sv =====
// command sequencer: cursor, cell updates, scroll copy and fill sweeps
`default_nettype none

module tmcw_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int CELLS   = COLUMNS * ROWS,
    parameter int ADDR_W  = $clog2(CELLS),
    parameter int COL_W   = $clog2(COLUMNS),
    parameter int ROW_W   = $clog2(ROWS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [tmcw_pkg::KIND_W-1:0]   kind,
    input  wire logic [tmcw_pkg::CHAR_W-1:0]   char_code,
    input  wire logic [tmcw_pkg::CHAR_W-1:0]   attr,
    input  wire logic [tmcw_pkg::COL_F_W-1:0]  col,
    input  wire logic [tmcw_pkg::ROW_F_W-1:0]  row,
    input  wire logic [tmcw_pkg::CHAR_W-1:0]   text_color,
    output logic                               busy,
    output logic                               done,
    output logic      [COL_W-1:0]              cur_col,
    output logic      [ROW_W-1:0]              cur_row,
    output logic      [ADDR_W-1:0]             cur_idx,
    output logic      [tmcw_pkg::CELL_W-1:0]   cell_value,
    output logic                               mem_we,
    output logic      [ADDR_W-1:0]             mem_waddr,
    output logic      [tmcw_pkg::CELL_W-1:0]   mem_wdata,
    output logic      [ADDR_W-1:0]             mem_raddr,
    input  wire logic [tmcw_pkg::CELL_W-1:0]   mem_rdata
);

    localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] SCROLL_BASE = ADDR_W'(CELLS - COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
    localparam logic [tmcw_pkg::CCMP_W-1:0] COLS_C = tmcw_pkg::CCMP_W'(COLUMNS);
    localparam logic [tmcw_pkg::RCMP_W-1:0] ROWS_C = tmcw_pkg::RCMP_W'(ROWS);

    tmcw_pkg::tmcw_state_t state_reg, state_next;

    logic [COL_W-1:0]                col_reg, col_next;
    logic [ROW_W-1:0]                row_reg, row_next;
    logic [ADDR_W-1:0]               sweep_reg, sweep_next;
    logic                            pend_v_reg, pend_v_next;
    logic [ADDR_W-1:0]               pend_addr_reg, pend_addr_next;
    logic                            done_reg, done_next;
    logic [tmcw_pkg::CELL_W-1:0]     cell_reg, cell_next;
    logic                            report_reg, report_next;
    logic [tmcw_pkg::CHAR_W-1:0]     fill_color_reg, fill_color_next;

    logic [ADDR_W-1:0]               idx;
    logic [ADDR_W-1:0]               in_addr;
    logic                            in_range;
    logic                            new_row;
    logic [tmcw_pkg::CCMP_W-1:0]     cc, cs;
    logic [tmcw_pkg::RCMP_W-1:0]     rc, rs;

    assign idx     = ADDR_W'(row_reg) * COLS_A + ADDR_W'(col_reg);
    assign in_addr = ADDR_W'(row) * COLS_A + ADDR_W'(col);
    assign cc      = tmcw_pkg::CCMP_W'(col_reg);
    assign cs      = tmcw_pkg::CCMP_W'(col);
    assign rc      = tmcw_pkg::RCMP_W'(row_reg);
    assign rs      = tmcw_pkg::RCMP_W'(row);
    assign in_range = (cs < COLS_C) && (rs < ROWS_C);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tmcw_pkg::ST_FILL;
            col_reg        <= '0;
            row_reg        <= '0;
            sweep_reg      <= '0;
            pend_v_reg     <= 1'b0;
            done_reg       <= 1'b0;
            report_reg     <= 1'b0;
            fill_color_reg <= tmcw_pkg::RESET_COLOR;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            sweep_reg      <= sweep_next;
            pend_v_reg     <= pend_v_next;
            done_reg       <= done_next;
            report_reg     <= report_next;
            fill_color_reg <= fill_color_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        cell_reg      <= cell_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        sweep_next      = sweep_reg;
        pend_v_next     = 1'b0;
        pend_addr_next  = pend_addr_reg;
        done_next       = 1'b0;
        cell_next       = cell_reg;
        report_next     = report_reg;
        fill_color_next = fill_color_reg;
        new_row         = 1'b0;
        mem_we          = pend_v_reg;
        mem_waddr       = pend_addr_reg;
        mem_wdata       = mem_rdata;
        mem_raddr       = sweep_reg;

        unique case (state_reg)
            tmcw_pkg::ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = {fill_color_reg, tmcw_pkg::SPACE_CODE};
                if (sweep_reg == LAST_CELL)
                begin
                    state_next  = tmcw_pkg::ST_IDLE;
                    done_next   = report_reg;
                    cell_next   = '0;
                    report_next = 1'b0;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            tmcw_pkg::ST_IDLE:
            begin
                mem_raddr = in_addr;
                if (start)
                begin
                    done_next = 1'b1;
                    cell_next = '0;
                    unique case (kind)
                        tmcw_pkg::KIND_WRITE:
                        begin
                            if (char_code == tmcw_pkg::NEWLINE_CODE)
                            begin
                                new_row = 1'b1;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = idx;
                                mem_wdata = {text_color, char_code};
                                if (col_reg == LAST_COL)
                                begin
                                    new_row = 1'b1;
                                end
                                else
                                begin
                                    col_next = col_reg + 1'b1;
                                end
                            end
                            if (new_row)
                            begin
                                col_next = '0;
                                if (row_reg == LAST_ROW)
                                begin
                                    done_next  = 1'b0;
                                    state_next = tmcw_pkg::ST_COPY;
                                    sweep_next = COLS_A;
                                end
                                else
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                        end

                        tmcw_pkg::KIND_PUT:
                        begin
                            if (in_range)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = in_addr;
                                mem_wdata = {attr, char_code};
                            end
                        end

                        tmcw_pkg::KIND_BACK:
                        begin
                            priority if (rc < rs)
                            begin
                                col_next = col_reg;
                            end
                            else if ((rc == rs) && (cc <= cs))
                            begin
                                col_next = col_reg;
                            end
                            else if (col_reg != '0)
                            begin
                                col_next  = col_reg - 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = idx - 1'b1;
                                mem_wdata = {text_color, tmcw_pkg::SPACE_CODE};
                            end
                            else if ((row_reg == '0) || (rc <= rs))
                            begin
                                col_next = col_reg;
                            end
                            else
                            begin
                                row_next  = row_reg - 1'b1;
                                col_next  = LAST_COL;
                                mem_we    = 1'b1;
                                mem_waddr = idx - 1'b1;
                                mem_wdata = {text_color, tmcw_pkg::SPACE_CODE};
                            end
                        end

                        tmcw_pkg::KIND_CLEAR:
                        begin
                            done_next       = 1'b0;
                            col_next        = '0;
                            row_next        = '0;
                            sweep_next      = '0;
                            report_next     = 1'b1;
                            fill_color_next = text_color;
                            state_next      = tmcw_pkg::ST_FILL;
                        end

                        tmcw_pkg::KIND_READ:
                        begin
                            if (in_range)
                            begin
                                done_next  = 1'b0;
                                state_next = tmcw_pkg::ST_READ;
                            end
                        end

                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            tmcw_pkg::ST_READ:
            begin
                done_next  = 1'b1;
                cell_next  = mem_rdata;
                state_next = tmcw_pkg::ST_IDLE;
            end

            tmcw_pkg::ST_COPY:
            begin
                mem_raddr      = sweep_reg;
                pend_v_next    = 1'b1;
                pend_addr_next = sweep_reg - COLS_A;
                if (sweep_reg == LAST_CELL)
                begin
                    state_next = tmcw_pkg::ST_BLANK;
                    sweep_next = SCROLL_BASE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            tmcw_pkg::ST_BLANK:
            begin
                if (!pend_v_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = sweep_reg;
                    mem_wdata = {text_color, tmcw_pkg::SPACE_CODE};
                    if (sweep_reg == LAST_CELL)
                    begin
                        state_next = tmcw_pkg::ST_IDLE;
                        done_next  = 1'b1;
                        cell_next  = '0;
                    end
                    else
                    begin
                        sweep_next = sweep_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = tmcw_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != tmcw_pkg::ST_IDLE);
    assign done       = done_reg;
    assign cur_col    = col_reg;
    assign cur_row    = row_reg;
    assign cur_idx    = idx;
    assign cell_value = cell_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/text_mode_console_writer.sv =====
// top level of the text mode console writer: color register, sequencer, screen memory
// write char, put, backspace, out-of-range read, unused kinds: result the cycle after accept
// in-range read: result via the read state, from the registered memory read port
// scroll: copy then blank sweep; clear: fill sweep; one cell per cycle, blank waits for copy
// next command accepted at the edge that takes the result; the receiver cannot stall
// after reset a fill sweep over every cell runs with busy high; config writes accepted
`default_nettype none

module text_mode_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [tmcw_pkg::KIND_W-1:0]   kind,
    input  wire logic [tmcw_pkg::CHAR_W-1:0]   char_code,
    input  wire logic [tmcw_pkg::CHAR_W-1:0]   attr,
    input  wire logic [tmcw_pkg::COL_F_W-1:0]  col,
    input  wire logic [tmcw_pkg::ROW_F_W-1:0]  row,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tmcw_pkg::CHAR_W-1:0]   cfg_data,
    output logic                               done,
    output logic      [tmcw_pkg::COL_F_W-1:0]  cursor_col,
    output logic      [tmcw_pkg::ROW_F_W-1:0]  cursor_row,
    output logic      [tmcw_pkg::IDX_F_W-1:0]  cursor_index,
    output logic      [tmcw_pkg::CELL_W-1:0]   cell_value
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    logic [tmcw_pkg::CHAR_W-1:0] text_color_reg, text_color_next;
    logic [COL_W-1:0]            cur_col;
    logic [ROW_W-1:0]            cur_row;
    logic [ADDR_W-1:0]           cur_idx;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [tmcw_pkg::CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]           mem_raddr;
    logic [tmcw_pkg::CELL_W-1:0] mem_rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        text_color_next = text_color_reg;
        if (cfg_valid && cfg_ready)
        begin
            text_color_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= tmcw_pkg::RESET_COLOR;
        end
        else
        begin
            text_color_reg <= text_color_next;
        end
    end

    tmcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CELLS   (CELLS),
        .ADDR_W  (ADDR_W),
        .COL_W   (COL_W),
        .ROW_W   (ROW_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (kind),
        .char_code  (char_code),
        .attr       (attr),
        .col        (col),
        .row        (row),
        .text_color (text_color_reg),
        .busy       (busy),
        .done       (done),
        .cur_col    (cur_col),
        .cur_row    (cur_row),
        .cur_idx    (cur_idx),
        .cell_value (cell_value),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    tmcw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W),
        .DATA_W (tmcw_pkg::CELL_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cursor_col   = tmcw_pkg::COL_F_W'(cur_col);
    assign cursor_row   = tmcw_pkg::ROW_F_W'(cur_row);
    assign cursor_index = tmcw_pkg::IDX_F_W'(cur_idx);

    // a result is only given once the sequencer is back at rest
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // clear always enters the fill sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == tmcw_pkg::KIND_CLEAR)) |=> (busy && !done))
        else $error("clear did not start the sweep");

    // cursor is on the screen whenever a result is given
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((int'(cur_row) < ROWS) && (int'(cur_col) < COLUMNS)))
        else $error("cursor off screen");

    // no memory write in the idle state without an accepted command
    assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start && !$past(busy)) |-> !mem_we)
        else $error("stray memory write");

endmodule

`default_nettype wire

// ===== dv/tb_text_mode_console_writer.sv =====
// self-checking testbench for the text mode console writer
`timescale 1ns / 100ps

module tb_text_mode_console_writer;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int PHASES  = 6;
    localparam int PHASE_ITEMS = 184;

    // kinds the block leaves alone
    localparam logic [tmcw_pkg::KIND_W-1:0] KIND_NOP_LO = 3'd5;
    localparam logic [tmcw_pkg::KIND_W-1:0] KIND_NOP_HI = 3'd7;

    typedef struct packed {
        logic [tmcw_pkg::COL_F_W-1:0] col;
        logic [tmcw_pkg::ROW_F_W-1:0] row;
        logic [tmcw_pkg::IDX_F_W-1:0] idx;
        logic [tmcw_pkg::CELL_W-1:0]  cval;
    } cursor_res_t;

    typedef struct packed {
        logic [tmcw_pkg::KIND_W-1:0]  k;
        logic [tmcw_pkg::CHAR_W-1:0]  ch;
        logic [tmcw_pkg::CHAR_W-1:0]  at;
        logic [tmcw_pkg::COL_F_W-1:0] c;
        logic [tmcw_pkg::ROW_F_W-1:0] r;
        logic                         typed;
        cursor_res_t                  want;
    } stim_row_t;

    localparam cursor_res_t HOME_NONE  = '0;
    localparam cursor_res_t HOME_BLANK =
        '{7'd0, 5'd0, 11'd0, {tmcw_pkg::RESET_COLOR, tmcw_pkg::SPACE_CODE}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [tmcw_pkg::KIND_W-1:0] kind = tmcw_pkg::KIND_WRITE;
    logic [tmcw_pkg::CHAR_W-1:0] char_code = '0;
    logic [tmcw_pkg::CHAR_W-1:0] attr = '0;
    logic [tmcw_pkg::COL_F_W-1:0] col = '0;
    logic [tmcw_pkg::ROW_F_W-1:0] row = '0;
    logic cfg_valid = 1'b0;
    logic [tmcw_pkg::CHAR_W-1:0] cfg_data = '0;
    logic busy;
    logic cfg_ready;
    logic done;
    logic [tmcw_pkg::COL_F_W-1:0] cursor_col;
    logic [tmcw_pkg::ROW_F_W-1:0] cursor_row;
    logic [tmcw_pkg::IDX_F_W-1:0] cursor_index;
    logic [tmcw_pkg::CELL_W-1:0] cell_value;

    // screen shadow, cursor and current color
    logic [tmcw_pkg::CELL_W-1:0] shadow_scr [CELLS];
    int pos_c;
    int pos_r;
    logic [tmcw_pkg::CHAR_W-1:0] ink;

    cursor_res_t cursor_due_q [$];
    int err_count = 0;
    int sent_count = 0;
    int burst_left = 0;
    bit pace_on = 1'b1;

    stim_row_t dir_tab [0:24] = '{
        '{tmcw_pkg::KIND_READ,  8'h00, 8'h00, 7'd0,   5'd0,  1'b1, HOME_BLANK},
        '{tmcw_pkg::KIND_READ,  8'h00, 8'h00, 7'd79,  5'd24, 1'b1, HOME_BLANK},
        '{tmcw_pkg::KIND_READ,  8'hFF, 8'hFF, 7'd127, 5'd31, 1'b1, HOME_NONE},
        '{tmcw_pkg::KIND_READ,  8'h00, 8'h00, 7'd80,  5'd0,  1'b1, HOME_NONE},
        '{tmcw_pkg::KIND_READ,  8'h00, 8'h00, 7'd0,   5'd25, 1'b1, HOME_NONE},
        '{KIND_NOP_LO, 8'hFF, 8'hFF, 7'd127, 5'd31, 1'b1, HOME_NONE},
        '{KIND_NOP_HI, 8'h00, 8'h00, 7'd0,  5'd0,  1'b1, HOME_NONE},
        '{tmcw_pkg::KIND_WRITE, 8'h41, 8'h00, 7'd0,   5'd0,  1'b0, HOME_NONE},
        '{tmcw_pkg::KIND_WRITE, 8'hFF, 8'hFF, 7'd127, 5'd31, 1'b0, HOME_NONE},
        '{tmcw_pkg::KIND_WRITE, 8'h00, 8'h00, 7'd0,   5'd0,  1'b0, HOME_NONE},
        '{tmcw_pkg::KIND_PUT,   8'hFF, 8'hFF, 7'd79,  5'd24, 1'b0, HOME_NONE},
        '{tmcw_pkg::KIND_PUT,   8'h00, 8'h00, 7'd0,   5'd0,  1'b0, HOME_NONE},
        '{tmcw_pkg::KIND_PUT,   8'h11, 8'h22, 7'd80,  5'd0,  1'b0, HOME_NONE},
        '{tmcw_pkg::KIND_PUT,   8'h33, 8'h44, 7'd0,   5'd25, 1'b0, HOME_NONE},
        '{tmcw_pkg::KIND_READ,  8'h00, 8'h00, 7'd79,  5'd24, 1'b0, HOME_NONE},
        '{tmcw_pkg::KIND_READ,  8'h00, 8'h00, 7'd0,   5'd0,  1'b0, HOME_NONE},
        '{tmcw_pkg::KIND_BACK,  8'h00, 8'h00, 7'd5,   5'd0,  1'b0, HOME_NONE},
        '{tmcw_pkg::KIND_BACK,  8'h00, 8'h00, 7'd0,   5'd3,  1'b0, HOME_NONE},
        '{tmcw_pkg::KIND_BACK,  8'h00, 8'h00, 7'd0,   5'd0,  1'b0, HOME_NONE},
        '{tmcw_pkg::KIND_WRITE, tmcw_pkg::NEWLINE_CODE, 8'h00, 7'd0, 5'd0, 1'b0, HOME_NONE},
        '{tmcw_pkg::KIND_BACK,  8'h00, 8'h00, 7'd0,   5'd0,  1'b0, HOME_NONE},
        '{tmcw_pkg::KIND_WRITE, tmcw_pkg::NEWLINE_CODE, 8'h00, 7'd0, 5'd0, 1'b0, HOME_NONE},
        '{tmcw_pkg::KIND_BACK,  8'h00, 8'h00, 7'd0,   5'd1,  1'b0, HOME_NONE},
        '{tmcw_pkg::KIND_CLEAR, 8'hFF, 8'hFF, 7'd127, 5'd31, 1'b1, HOME_NONE},
        '{tmcw_pkg::KIND_READ,  8'h00, 8'h00, 7'd79,  5'd24, 1'b1, HOME_BLANK}
    };

    text_mode_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .char_code    (char_code),
        .attr         (attr),
        .col          (col),
        .row          (row),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .cursor_col   (cursor_col),
        .cursor_row   (cursor_row),
        .cursor_index (cursor_index),
        .cell_value   (cell_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [tmcw_pkg::CELL_W-1:0] blank_cell();
        return {ink, tmcw_pkg::SPACE_CODE};
    endfunction

    // next row, scrolling up at the bottom
    task automatic line_feed();
        pos_c = 0;
        if (pos_r == ROWS - 1)
        begin
            for (int i = 0; i < CELLS - COLUMNS; i++)
                shadow_scr[i] = shadow_scr[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                shadow_scr[i] = blank_cell();
        end
        else
            pos_r++;
    endtask

    task automatic console_apply(input logic [tmcw_pkg::KIND_W-1:0] k,
                                 input logic [tmcw_pkg::CHAR_W-1:0] ch,
                                 input logic [tmcw_pkg::CHAR_W-1:0] at,
                                 input logic [tmcw_pkg::COL_F_W-1:0] c,
                                 input logic [tmcw_pkg::ROW_F_W-1:0] r,
                                 output cursor_res_t res);
        int sc;
        int sr;
        bit in_range;
        logic [tmcw_pkg::CELL_W-1:0] got;
        sc = c;
        sr = r;
        in_range = (sc < COLUMNS) && (sr < ROWS);
        got = '0;
        case (k)
            tmcw_pkg::KIND_WRITE:
            begin
                if (ch == tmcw_pkg::NEWLINE_CODE)
                    line_feed();
                else
                begin
                    shadow_scr[pos_r * COLUMNS + pos_c] = {ink, ch};
                    pos_c++;
                    if (pos_c >= COLUMNS)
                        line_feed();
                end
            end
            tmcw_pkg::KIND_PUT:
                if (in_range)
                    shadow_scr[sr * COLUMNS + sc] = {at, ch};
            tmcw_pkg::KIND_BACK:
            begin
                if (pos_r < sr || (pos_r == sr && pos_c <= sc))
                    ;
                else if (pos_c > 0)
                begin
                    pos_c--;
                    shadow_scr[pos_r * COLUMNS + pos_c] = blank_cell();
                end
                else if (pos_r != 0 && pos_r - 1 >= sr)
                begin
                    pos_r--;
                    pos_c = COLUMNS - 1;
                    shadow_scr[pos_r * COLUMNS + pos_c] = blank_cell();
                end
            end
            tmcw_pkg::KIND_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    shadow_scr[i] = blank_cell();
                pos_c = 0;
                pos_r = 0;
            end
            tmcw_pkg::KIND_READ:
                if (in_range)
                    got = shadow_scr[sr * COLUMNS + sc];
            default: ;
        endcase
        res.col  = tmcw_pkg::COL_F_W'(pos_c);
        res.row  = tmcw_pkg::ROW_F_W'(pos_r);
        res.idx  = tmcw_pkg::IDX_F_W'(pos_r * COLUMNS + pos_c);
        res.cval = got;
    endtask

    task automatic push_item(input logic [tmcw_pkg::KIND_W-1:0] k,
                             input logic [tmcw_pkg::CHAR_W-1:0] ch,
                             input logic [tmcw_pkg::CHAR_W-1:0] at,
                             input logic [tmcw_pkg::COL_F_W-1:0] c,
                             input logic [tmcw_pkg::ROW_F_W-1:0] r, input bit typed,
                             input cursor_res_t typed_res);
        cursor_res_t res;
        start     <= 1'b1;
        kind      <= k;
        char_code <= ch;
        attr      <= at;
        col       <= c;
        row       <= r;
        do @(posedge clk); while (busy);
        console_apply(k, ch, at, c, r, res);
        cursor_due_q.push_back(typed ? typed_res : res);
        sent_count++;
    endtask

    // when pacing is on: bursts of random length, random gaps between them
    task automatic pace_gap();
        if (pace_on)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                start <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
        end
    endtask

    task automatic emit(input logic [tmcw_pkg::KIND_W-1:0] k,
                        input logic [tmcw_pkg::CHAR_W-1:0] ch,
                        input logic [tmcw_pkg::CHAR_W-1:0] at,
                        input logic [tmcw_pkg::COL_F_W-1:0] c,
                        input logic [tmcw_pkg::ROW_F_W-1:0] r);
        push_item(k, ch, at, c, r, 1'b0, HOME_NONE);
        pace_gap();
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (cursor_due_q.size() != 0 || busy);
    endtask

    task automatic set_ink(input logic [tmcw_pkg::CHAR_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        ink = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_sequence();
        int sel;
        int sr;
        int sc;
        logic [tmcw_pkg::CHAR_W-1:0] ch;
        logic [tmcw_pkg::COL_F_W-1:0] c;
        logic [tmcw_pkg::ROW_F_W-1:0] r;
        sel = $urandom_range(0, 99);
        if (sel < 45)
        begin
            repeat ($urandom_range(1, 90))
            begin
                ch = ($urandom_range(0, 11) == 0) ? tmcw_pkg::NEWLINE_CODE
                                                  : tmcw_pkg::CHAR_W'($urandom);
                emit(tmcw_pkg::KIND_WRITE, ch, tmcw_pkg::CHAR_W'($urandom),
                     tmcw_pkg::COL_F_W'($urandom), tmcw_pkg::ROW_F_W'($urandom));
            end
        end
        else if (sel < 53)
        begin
            repeat ($urandom_range(1, 20))
                emit(tmcw_pkg::KIND_WRITE, tmcw_pkg::NEWLINE_CODE, tmcw_pkg::CHAR_W'($urandom),
                     tmcw_pkg::COL_F_W'($urandom), tmcw_pkg::ROW_F_W'($urandom));
        end
        else if (sel < 65)
        begin
            // backspace run down to a guard, mostly at or before the cursor, sometimes random
            sr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, pos_r);
            sc = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 127) : $urandom_range(0, pos_c);
            repeat ($urandom_range(1, 12))
                emit(tmcw_pkg::KIND_BACK, tmcw_pkg::CHAR_W'($urandom),
                     tmcw_pkg::CHAR_W'($urandom), tmcw_pkg::COL_F_W'(sc),
                     tmcw_pkg::ROW_F_W'(sr));
        end
        else if (sel < 80)
        begin
            if ($urandom_range(0, 9) != 0)
            begin
                c = tmcw_pkg::COL_F_W'($urandom_range(0, COLUMNS - 1));
                r = tmcw_pkg::ROW_F_W'($urandom_range(0, ROWS - 1));
            end
            else
            begin
                c = tmcw_pkg::COL_F_W'($urandom);
                r = tmcw_pkg::ROW_F_W'($urandom);
            end
            emit(tmcw_pkg::KIND_PUT, tmcw_pkg::CHAR_W'($urandom), tmcw_pkg::CHAR_W'($urandom),
                 c, r);
            emit(tmcw_pkg::KIND_READ, tmcw_pkg::CHAR_W'($urandom), tmcw_pkg::CHAR_W'($urandom),
                 c, r);
        end
        else if (sel < 93)
        begin
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(0, 9) != 0)
                begin
                    c = tmcw_pkg::COL_F_W'($urandom_range(0, COLUMNS - 1));
                    r = tmcw_pkg::ROW_F_W'($urandom_range(0, ROWS - 1));
                end
                else
                begin
                    c = tmcw_pkg::COL_F_W'($urandom);
                    r = tmcw_pkg::ROW_F_W'($urandom);
                end
                emit(tmcw_pkg::KIND_READ, tmcw_pkg::CHAR_W'($urandom),
                     tmcw_pkg::CHAR_W'($urandom), c, r);
            end
        end
        else if (sel < 96)
            emit(tmcw_pkg::KIND_W'($urandom_range(KIND_NOP_LO, KIND_NOP_HI)),
                 tmcw_pkg::CHAR_W'($urandom), tmcw_pkg::CHAR_W'($urandom),
                 tmcw_pkg::COL_F_W'($urandom), tmcw_pkg::ROW_F_W'($urandom));
        else if (sel < 98)
            emit(tmcw_pkg::KIND_CLEAR, tmcw_pkg::CHAR_W'($urandom), tmcw_pkg::CHAR_W'($urandom),
                 tmcw_pkg::COL_F_W'($urandom), tmcw_pkg::ROW_F_W'($urandom));
        else
            emit(tmcw_pkg::KIND_W'($urandom), tmcw_pkg::CHAR_W'($urandom),
                 tmcw_pkg::CHAR_W'($urandom), tmcw_pkg::COL_F_W'($urandom),
                 tmcw_pkg::ROW_F_W'($urandom));
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d (0x%0h) actual %0d (0x%0h)",
                     $time, name, want, want, got, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_mon
        cursor_res_t want;
        if (rst_n && done)
        begin
            if (cursor_due_q.size() == 0)
            begin
                $display("%0t: unexpected transaction, actual col %0d row %0d cell 0x%0h",
                         $time, cursor_col, cursor_row, cell_value);
                err_count++;
            end
            else
            begin
                want = cursor_due_q.pop_front();
                check_field("cursor_col", want.col, cursor_col);
                check_field("cursor_row", want.row, cursor_row);
                check_field("cursor_index", want.idx, cursor_index);
                check_field("cell_value", want.cval, cell_value);
            end
        end
    end

    initial
    begin
        #150_000_000;
        $display("tb_text_mode_console_writer: errors");
        $finish;
    end

    initial
    begin
        ink = tmcw_pkg::RESET_COLOR;
        pos_c = 0;
        pos_r = 0;
        for (int i = 0; i < CELLS; i++)
            shadow_scr[i] = {tmcw_pkg::RESET_COLOR, tmcw_pkg::SPACE_CODE};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // power-up fill sweep
        do @(posedge clk); while (busy);

        foreach (dir_tab[i])
        begin
            push_item(dir_tab[i].k, dir_tab[i].ch, dir_tab[i].at, dir_tab[i].c, dir_tab[i].r,
                      dir_tab[i].typed, dir_tab[i].want);
            pace_gap();
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_ink(8'h00);
                1: set_ink(8'hFF);
                2: set_ink(8'h80);
                3: set_ink(8'h0F);
                default: set_ink(tmcw_pkg::CHAR_W'($urandom));
            endcase
            pace_on = (ph != 2);
            sent_count = 0;
            while (sent_count < PHASE_ITEMS / 2)
                random_sequence();
            drain();
            while (sent_count < PHASE_ITEMS)
                random_sequence();
        end

        drain();
        repeat (CELLS + 16) @(posedge clk);
        if (err_count == 0)
            $display("tb_text_mode_console_writer: clean");
        else
            $display("tb_text_mode_console_writer: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tmcw_pkg.sv
hw/rtl/tmcw_screen_ram.sv
hw/rtl/tmcw_ctrl.sv
hw/rtl/text_mode_console_writer.sv
dv/tb_text_mode_console_writer.sv
